### hw/rtl/ngll_pkg.sv
// ----------------------------------------------------------------------------
// NMEA GLL checker package
// Shared constants, codes and small decode functions for the GLL checker.
// ----------------------------------------------------------------------------
package ngll_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int CNT_W         = 32;
  localparam int NUM_CNT       = 6;
  localparam int MIN_FIELDS    = 8;
  localparam int PREFIX_LEN    = 7;
  localparam int UTC_MIN_LEN   = 6;
  localparam int IN_W          = 8;
  localparam int OUT_W         = 216;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_FIX_A = 8'h41;

  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_NOT_GLL   = 3'd1,
    OUT_CSUM_ERR  = 3'd2,
    OUT_BAD_FIX   = 3'd3,
    OUT_GOOD_FIX  = 3'd4,
    OUT_OVERFLOW  = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    TAG_OTHER    = 3'd0,
    TAG_LAT      = 3'd1,
    TAG_LAT_HEMI = 3'd2,
    TAG_LON      = 3'd3,
    TAG_LON_HEMI = 3'd4,
    TAG_UTC      = 3'd5,
    TAG_STATUS   = 3'd6,
    TAG_MODE     = 3'd7
  } tag_t;

  typedef enum logic [2:0] {
    CNT_LINES = 3'd0,
    CNT_GLL   = 3'd1,
    CNT_CSUM  = 3'd2,
    CNT_BAD   = 3'd3,
    CNT_GOOD  = 3'd4,
    CNT_DROP  = 3'd5
  } cnt_idx_t;

  typedef enum logic [1:0] {
    STAR_NONE = 2'd0,
    STAR_SEEN = 2'd1,
    STAR_ONE  = 2'd2,
    STAR_TWO  = 2'd3
  } star_t;

  // Expected character of the sentence prefix "$GNGLL," at a given position.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4e;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h4c;
      3'd5:    ch = 8'h4c;
      3'd6:    ch = 8'h2c;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Hex digit value; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

endpackage

### hw/rtl/nmea_gll_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA GLL sentence checker
// Byte-stream checker that frames lines, verifies $GNGLL checksums and fields,
// tags each byte with its field and keeps wrapping event counters.
// ----------------------------------------------------------------------------
// The block takes one character per beat and returns one result beat per
// character in the next cycle, at one beat per clock while not stalled. All
// per-line state is updated by a single layer of logic between the line state
// registers and the output register, so a new character is taken in every
// cycle as long as the output register is empty or being drained. Results
// appear in input order; the counters in each result already include the
// effect of that character.
module nmea_gll_sentence_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ngll_pkg::IN_W-1:0]   in_tdata,   // [7:0] data_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] char_echo, [10:8] field_tag, [13:11] outcome, [21:14] checksum_value,
  // [53:22] lines_seen, [85:54] gll_lines_seen, [117:86] checksum_failures,
  // [149:118] bad_fixes, [181:150] good_fixes, [213:182] dropped_lines,
  // [215:214] zero
  output logic [ngll_pkg::OUT_W-1:0]  out_tdata
);

  logic [ngll_pkg::LEN_W-1:0] line_length_r, line_length_nxt;
  logic                       dropping_r, dropping_nxt;
  logic [2:0]                 prefix_progress_r, prefix_progress_nxt;
  logic                       prefix_failed_r, prefix_failed_nxt;
  logic [7:0]                 running_xor_r, running_xor_nxt;
  ngll_pkg::star_t            star_r, star_nxt;
  logic [7:0]                 expected_sum_r, expected_sum_nxt;
  logic [3:0]                 token_index_r, token_index_nxt;
  logic [6:0]                 token_length_r, token_length_nxt;
  logic                       fields_ok_r, fields_ok_nxt;
  logic                       utc_dot_seen_r, utc_dot_seen_nxt;
  logic [ngll_pkg::CNT_W-1:0] cnt_r   [ngll_pkg::NUM_CNT];
  logic [ngll_pkg::CNT_W-1:0] cnt_nxt [ngll_pkg::NUM_CNT];

  logic                       out_tvalid_r;
  logic [ngll_pkg::OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                       accept;
  logic [7:0]                 c;
  ngll_pkg::tag_t             tag;
  ngll_pkg::outcome_t         outcome;
  logic [7:0]                 sum_out;
  logic                       close_bad;
  logic [3:0]                 f;
  logic [6:0]                 tpos;
  logic                       dot_now;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;

  // A field that closes with the wrong length clears the fields-good flag.
  always_comb begin
    logic [3:0] fc;
    fc = token_index_r - 4'd1;
    close_bad = 1'b0;
    if (token_length_r != 7'd0 && token_index_r != 4'd0) begin
      if ((fc == 4'd2 || fc == 4'd4 || fc == 4'd6 || fc == 4'd7) &&
          token_length_r != 7'd1) begin
        close_bad = 1'b1;
      end
      if (fc == 4'd5 && !utc_dot_seen_r &&
          token_length_r < 7'(ngll_pkg::UTC_MIN_LEN)) begin
        close_bad = 1'b1;
      end
    end
  end

  always_comb begin
    line_length_nxt     = line_length_r;
    dropping_nxt        = dropping_r;
    prefix_progress_nxt = prefix_progress_r;
    prefix_failed_nxt   = prefix_failed_r;
    running_xor_nxt     = running_xor_r;
    star_nxt            = star_r;
    expected_sum_nxt    = expected_sum_r;
    token_index_nxt     = token_index_r;
    token_length_nxt    = token_length_r;
    fields_ok_nxt       = fields_ok_r;
    utc_dot_seen_nxt    = utc_dot_seen_r;
    for (int i = 0; i < ngll_pkg::NUM_CNT; i++) cnt_nxt[i] = cnt_r[i];
    tag      = ngll_pkg::TAG_OTHER;
    outcome  = ngll_pkg::OUT_NONE;
    sum_out  = 8'd0;
    f        = 4'd0;
    tpos     = 7'd0;
    dot_now  = 1'b0;

    if (c == ngll_pkg::CH_CR || c == ngll_pkg::CH_LF) begin
      if (dropping_r || line_length_r != '0) begin
        if (!dropping_r) begin
          cnt_nxt[ngll_pkg::CNT_LINES] = cnt_r[ngll_pkg::CNT_LINES] + 32'd1;
          if (prefix_failed_r || prefix_progress_r < 3'(ngll_pkg::PREFIX_LEN)) begin
            outcome = ngll_pkg::OUT_NOT_GLL;
          end else begin
            cnt_nxt[ngll_pkg::CNT_GLL] = cnt_r[ngll_pkg::CNT_GLL] + 32'd1;
            sum_out = running_xor_r;
            if (star_r != ngll_pkg::STAR_TWO || running_xor_r != expected_sum_r) begin
              cnt_nxt[ngll_pkg::CNT_CSUM] = cnt_r[ngll_pkg::CNT_CSUM] + 32'd1;
              outcome = ngll_pkg::OUT_CSUM_ERR;
            end else if (!fields_ok_r || token_index_r < 4'(ngll_pkg::MIN_FIELDS)) begin
              cnt_nxt[ngll_pkg::CNT_BAD] = cnt_r[ngll_pkg::CNT_BAD] + 32'd1;
              outcome = ngll_pkg::OUT_BAD_FIX;
            end else begin
              cnt_nxt[ngll_pkg::CNT_GOOD] = cnt_r[ngll_pkg::CNT_GOOD] + 32'd1;
              outcome = ngll_pkg::OUT_GOOD_FIX;
            end
          end
        end
        dropping_nxt        = 1'b0;
        line_length_nxt     = '0;
        prefix_progress_nxt = 3'd0;
        prefix_failed_nxt   = 1'b0;
        running_xor_nxt     = 8'd0;
        star_nxt            = ngll_pkg::STAR_NONE;
        expected_sum_nxt    = 8'd0;
        token_index_nxt     = 4'd0;
        token_length_nxt    = 7'd0;
        fields_ok_nxt       = 1'b1;
        utc_dot_seen_nxt    = 1'b0;
      end
    end else if (!dropping_r) begin
      if (line_length_r >= ngll_pkg::LEN_W'(ngll_pkg::LINE_CAPACITY - 1)) begin
        dropping_nxt        = 1'b1;
        line_length_nxt     = '0;
        prefix_progress_nxt = 3'd0;
        prefix_failed_nxt   = 1'b0;
        running_xor_nxt     = 8'd0;
        star_nxt            = ngll_pkg::STAR_NONE;
        expected_sum_nxt    = 8'd0;
        token_index_nxt     = 4'd0;
        token_length_nxt    = 7'd0;
        fields_ok_nxt       = 1'b1;
        utc_dot_seen_nxt    = 1'b0;
        cnt_nxt[ngll_pkg::CNT_DROP] = cnt_r[ngll_pkg::CNT_DROP] + 32'd1;
        outcome = ngll_pkg::OUT_OVERFLOW;
      end else begin
        line_length_nxt = line_length_r + 1'b1;
        if (line_length_r < ngll_pkg::LEN_W'(ngll_pkg::PREFIX_LEN)) begin
          if (c != ngll_pkg::prefix_char(line_length_r[2:0])) prefix_failed_nxt = 1'b1;
          prefix_progress_nxt = prefix_progress_r + 3'd1;
        end
        if (line_length_r != '0) begin
          if (star_r == ngll_pkg::STAR_NONE) begin
            if (c == ngll_pkg::CH_STAR) begin
              if (close_bad) fields_ok_nxt = 1'b0;
              star_nxt = ngll_pkg::STAR_SEEN;
            end else begin
              running_xor_nxt = running_xor_r ^ c;
              if (c == ngll_pkg::CH_COMMA) begin
                if (close_bad) fields_ok_nxt = 1'b0;
                token_length_nxt = 7'd0;
              end else begin
                if (token_length_r == 7'd0 && token_index_r != 4'd15) begin
                  token_index_nxt = token_index_r + 4'd1;
                end
                f    = token_index_nxt - 4'd1;
                tpos = token_length_r;
                if (token_length_r != 7'd127) token_length_nxt = token_length_r + 7'd1;
                if (f == 4'd6 && tpos == 7'd0 && c != ngll_pkg::CH_FIX_A) begin
                  fields_ok_nxt = 1'b0;
                end
                if (f == 4'd5) begin
                  dot_now = (c == ngll_pkg::CH_DOT) && !utc_dot_seen_r;
                  if (dot_now) begin
                    utc_dot_seen_nxt = 1'b1;
                    if (tpos < 7'(ngll_pkg::UTC_MIN_LEN)) fields_ok_nxt = 1'b0;
                  end
                  if (!utc_dot_seen_r && !dot_now && tpos < 7'(ngll_pkg::UTC_MIN_LEN)) begin
                    tag = ngll_pkg::TAG_UTC;
                  end
                end else if (f >= 4'd1 && f <= 4'd7) begin
                  tag = ngll_pkg::tag_t'(f[2:0]);
                end
                if (prefix_failed_r) tag = ngll_pkg::TAG_OTHER;
              end
            end
          end else if (star_r != ngll_pkg::STAR_TWO) begin
            expected_sum_nxt = {expected_sum_r[3:0], ngll_pkg::hex_value(c)};
            star_nxt         = ngll_pkg::star_t'(star_r + 2'd1);
          end
        end
      end
    end

    out_tdata_nxt = {2'b00,
                     cnt_nxt[ngll_pkg::CNT_DROP], cnt_nxt[ngll_pkg::CNT_GOOD],
                     cnt_nxt[ngll_pkg::CNT_BAD],  cnt_nxt[ngll_pkg::CNT_CSUM],
                     cnt_nxt[ngll_pkg::CNT_GLL],  cnt_nxt[ngll_pkg::CNT_LINES],
                     sum_out, outcome, tag, c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r     <= '0;
      dropping_r        <= 1'b0;
      prefix_progress_r <= 3'd0;
      prefix_failed_r   <= 1'b0;
      running_xor_r     <= 8'd0;
      star_r            <= ngll_pkg::STAR_NONE;
      expected_sum_r    <= 8'd0;
      token_index_r     <= 4'd0;
      token_length_r    <= 7'd0;
      fields_ok_r       <= 1'b1;
      utc_dot_seen_r    <= 1'b0;
      for (int i = 0; i < ngll_pkg::NUM_CNT; i++) cnt_r[i] <= '0;
      out_tvalid_r      <= 1'b0;
    end else begin
      if (accept) begin
        line_length_r     <= line_length_nxt;
        dropping_r        <= dropping_nxt;
        prefix_progress_r <= prefix_progress_nxt;
        prefix_failed_r   <= prefix_failed_nxt;
        running_xor_r     <= running_xor_nxt;
        star_r            <= star_nxt;
        expected_sum_r    <= expected_sum_nxt;
        token_index_r     <= token_index_nxt;
        token_length_r    <= token_length_nxt;
        fields_ok_r       <= fields_ok_nxt;
        utc_dot_seen_r    <= utc_dot_seen_nxt;
        for (int i = 0; i < ngll_pkg::NUM_CNT; i++) cnt_r[i] <= cnt_nxt[i];
        out_tvalid_r      <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### bench/nmea_gll_sentence_checker_tb.sv
// ----------------------------------------------------------------------------
// NMEA GLL sentence checker testbench
// Sends a short table of hand-picked characters, then random GLL sentences,
// corrupted sentences, noise and over-long lines. Every result beat is checked
// field by field against a predictor that runs inside the bench.
// ----------------------------------------------------------------------------
module nmea_gll_sentence_checker_tb;

  localparam int    RAND_ITEMS = 550;
  localparam string GLL_HEAD   = "$GNGLL,";

  typedef struct packed {
    logic [1:0]          pad;
    logic [31:0]         dropped;
    logic [31:0]         good;
    logic [31:0]         bad;
    logic [31:0]         csum_fail;
    logic [31:0]         gll;
    logic [31:0]         lines;
    logic [7:0]          csum;
    ngll_pkg::outcome_t  outcome;
    ngll_pkg::tag_t      tag;
    logic [7:0]          echo;
  } gll_result_t;

  typedef struct packed {
    logic [7:0]          ch;
    logic                typed;
    ngll_pkg::outcome_t  oc;
    logic [7:0]          sum;
    logic [31:0]         lines;
  } dir_row_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [ngll_pkg::IN_W-1:0]  in_tdata  = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [ngll_pkg::OUT_W-1:0] out_tdata;

  gll_result_t result_q [$];
  logic [7:0]  line_q [$];
  int unsigned err_cnt  = 0;
  int unsigned idle_pct = 10;

  // Predictor state for the line being received.
  int              ln_len;
  bit              in_drop;
  int              pfx_cnt;
  bit              pfx_bad;
  logic [7:0]      xor_acc;
  ngll_pkg::star_t star_state;
  logic [7:0]      sum_rx;
  logic [3:0]      tok_cnt;
  logic [6:0]      tok_len;
  bit              flds_good;
  bit              dot_seen;
  logic [31:0]     evt_cnt [ngll_pkg::NUM_CNT];

  // Two short sentences with a good and a one-digit checksum follow the
  // empty line and the extreme byte values.
  dir_row_t dir_tab [25] = '{
    '{8'h0a, 1'b1, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{8'h00, 1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{8'hff, 1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{8'h0d, 1'b1, ngll_pkg::OUT_NOT_GLL,  8'h00, 32'd1},
    '{"$",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"G",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"N",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"G",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"L",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"L",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{",",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"*",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"6",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"2",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{8'h0a, 1'b1, ngll_pkg::OUT_BAD_FIX,  8'h62, 32'd2},
    '{"$",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"G",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"N",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"G",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"L",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"L",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{",",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"*",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{"6",   1'b0, ngll_pkg::OUT_NONE,     8'h00, 32'd0},
    '{8'h0a, 1'b1, ngll_pkg::OUT_CSUM_ERR, 8'h62, 32'd3}
  };

  nmea_gll_sentence_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [3:0] nib_of(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
    return v;
  endfunction

  function automatic void clear_line_state();
    ln_len     = 0;
    pfx_cnt    = 0;
    pfx_bad    = 1'b0;
    xor_acc    = 8'h00;
    star_state = ngll_pkg::STAR_NONE;
    sum_rx     = 8'h00;
    tok_cnt    = 4'd0;
    tok_len    = 7'd0;
    flds_good  = 1'b1;
    dot_seen   = 1'b0;
  endfunction

  function automatic void close_token();
    logic [3:0] fld;
    if (tok_len == 0 || tok_cnt == 0) return;
    fld = tok_cnt - 4'd1;
    if ((fld == 2 || fld == 4 || fld == 6 || fld == 7) && tok_len != 1) flds_good = 1'b0;
    if (fld == 5 && !dot_seen && tok_len < ngll_pkg::UTC_MIN_LEN) flds_good = 1'b0;
  endfunction

  function automatic gll_result_t predict_byte(input logic [7:0] c);
    gll_result_t r;
    logic [3:0]  fld;
    logic [6:0]  tpos;
    int          pos;
    r         = '0;
    r.echo    = c;
    r.tag     = ngll_pkg::TAG_OTHER;
    r.outcome = ngll_pkg::OUT_NONE;
    if (c == ngll_pkg::CH_CR || c == ngll_pkg::CH_LF) begin
      if (in_drop) begin
        in_drop = 1'b0;
        clear_line_state();
      end else if (ln_len != 0) begin
        evt_cnt[ngll_pkg::CNT_LINES]++;
        if (pfx_bad || pfx_cnt < ngll_pkg::PREFIX_LEN) begin
          r.outcome = ngll_pkg::OUT_NOT_GLL;
        end else begin
          evt_cnt[ngll_pkg::CNT_GLL]++;
          r.csum = xor_acc;
          if (star_state != ngll_pkg::STAR_TWO || xor_acc != sum_rx) begin
            evt_cnt[ngll_pkg::CNT_CSUM]++;
            r.outcome = ngll_pkg::OUT_CSUM_ERR;
          end else if (!flds_good || tok_cnt < ngll_pkg::MIN_FIELDS) begin
            evt_cnt[ngll_pkg::CNT_BAD]++;
            r.outcome = ngll_pkg::OUT_BAD_FIX;
          end else begin
            evt_cnt[ngll_pkg::CNT_GOOD]++;
            r.outcome = ngll_pkg::OUT_GOOD_FIX;
          end
        end
        clear_line_state();
      end
    end else if (!in_drop) begin
      if (ln_len >= ngll_pkg::LINE_CAPACITY - 1) begin
        in_drop = 1'b1;
        clear_line_state();
        evt_cnt[ngll_pkg::CNT_DROP]++;
        r.outcome = ngll_pkg::OUT_OVERFLOW;
      end else begin
        pos = ln_len;
        ln_len++;
        if (pos < ngll_pkg::PREFIX_LEN) begin
          if (c != GLL_HEAD[pos]) pfx_bad = 1'b1;
          pfx_cnt++;
        end
        if (pos >= 1) begin
          if (star_state == ngll_pkg::STAR_NONE) begin
            if (c == ngll_pkg::CH_STAR) begin
              close_token();
              star_state = ngll_pkg::STAR_SEEN;
            end else begin
              xor_acc ^= c;
              if (c == ngll_pkg::CH_COMMA) begin
                close_token();
                tok_len = 7'd0;
              end else begin
                if (tok_len == 0 && tok_cnt < 15) tok_cnt++;
                fld  = tok_cnt - 4'd1;
                tpos = tok_len;
                if (tok_len < 127) tok_len++;
                if (fld == 6 && tpos == 0 && c != ngll_pkg::CH_FIX_A) flds_good = 1'b0;
                if (fld == 5) begin
                  if (c == ngll_pkg::CH_DOT && !dot_seen) begin
                    dot_seen = 1'b1;
                    if (tpos < ngll_pkg::UTC_MIN_LEN) flds_good = 1'b0;
                  end
                  if (!dot_seen && tpos < ngll_pkg::UTC_MIN_LEN) r.tag = ngll_pkg::TAG_UTC;
                end else if (fld >= 1 && fld <= 7) begin
                  r.tag = ngll_pkg::tag_t'(fld[2:0]);
                end
                if (pfx_bad) r.tag = ngll_pkg::TAG_OTHER;
              end
            end
          end else if (star_state != ngll_pkg::STAR_TWO) begin
            sum_rx     = {sum_rx[3:0], nib_of(c)};
            star_state = ngll_pkg::star_t'(star_state + 2'd1);
          end
        end
      end
    end
    r.lines     = evt_cnt[ngll_pkg::CNT_LINES];
    r.gll       = evt_cnt[ngll_pkg::CNT_GLL];
    r.csum_fail = evt_cnt[ngll_pkg::CNT_CSUM];
    r.bad       = evt_cnt[ngll_pkg::CNT_BAD];
    r.good      = evt_cnt[ngll_pkg::CNT_GOOD];
    r.dropped   = evt_cnt[ngll_pkg::CNT_DROP];
    return r;
  endfunction

  function automatic void push_text(input string t);
    for (int i = 0; i < t.len(); i++) line_q.push_back(t[i]);
  endfunction

  function automatic void push_pick(input string opts);
    line_q.push_back(opts[$urandom_range(0, opts.len() - 1)]);
  endfunction

  function automatic void push_digits(input int n);
    for (int i = 0; i < n; i++) line_q.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  // A separator now and then turns into an empty field.
  function automatic void push_sep();
    line_q.push_back(ngll_pkg::CH_COMMA);
    if ($urandom_range(0, 19) == 0) line_q.push_back(ngll_pkg::CH_COMMA);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 10) return 8'("0" + v);
    return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic void build_gll(input bit corrupt);
    logic [7:0] cs;
    int         pick;
    int         idx;
    bit         lower;
    push_text(GLL_HEAD);
    if ($urandom_range(0, 19) != 0) begin
      push_digits(4);
      push_text(".");
      push_digits($urandom_range(1, 5));
    end
    push_sep();
    if ($urandom_range(0, 19) == 0) push_pick("NSX");
    else push_pick("NS");
    if ($urandom_range(0, 29) == 0) push_pick("NS");
    push_sep();
    push_digits(5);
    push_text(".");
    push_digits($urandom_range(1, 5));
    push_sep();
    push_pick("EW");
    push_sep();
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      push_digits(6);
      push_text(".");
      push_digits($urandom_range(1, 3));
    end else if (pick == 6) begin
      push_digits(6);
    end else if (pick == 7) begin
      push_digits($urandom_range(7, 9));
    end else if (pick == 8) begin
      push_digits($urandom_range(0, 5));
      push_text(".");
      push_digits(2);
    end else begin
      push_digits($urandom_range(1, 5));
    end
    push_sep();
    if ($urandom_range(0, 4) == 0) push_pick("VAX");
    else push_pick("A");
    push_sep();
    push_pick("ADNE");
    if ($urandom_range(0, 19) == 0) push_pick("ADNE");
    if ($urandom_range(0, 7) == 0) begin
      push_sep();
      push_pick("XYZ");
      push_sep();
      push_digits($urandom_range(1, 3));
    end
    cs = 8'h00;
    for (int i = 1; i < line_q.size(); i++) cs ^= line_q[i];
    pick  = $urandom_range(0, 19);
    lower = ($urandom_range(0, 2) == 0);
    if (pick == 2) cs ^= 8'($urandom_range(1, 255));
    if (pick != 0) begin
      line_q.push_back(ngll_pkg::CH_STAR);
      line_q.push_back(hex_char(cs[7:4], lower));
      if (pick != 1) line_q.push_back(hex_char(cs[3:0], lower));
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(32, 126)));
    end
    if (corrupt) begin
      repeat ($urandom_range(1, 2)) begin
        idx         = $urandom_range(0, line_q.size() - 1);
        line_q[idx] = 8'($urandom_range(0, 255));
      end
    end
  endfunction

  function automatic void chk(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, nm, e, a);
      err_cnt++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    result_q.push_back(predict_byte(b));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  always @(posedge clk) begin
    gll_result_t act;
    gll_result_t exp_r;
    out_tready <= ($urandom_range(0, 99) >= idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      act = gll_result_t'(out_tdata);
      if (result_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, out_tdata);
        err_cnt++;
      end else begin
        exp_r = result_q.pop_front();
        chk("char_echo", exp_r.echo, act.echo);
        chk("field_tag", exp_r.tag, act.tag);
        chk("outcome", exp_r.outcome, act.outcome);
        chk("checksum_value", exp_r.csum, act.csum);
        chk("lines_seen", exp_r.lines, act.lines);
        chk("gll_lines_seen", exp_r.gll, act.gll);
        chk("checksum_failures", exp_r.csum_fail, act.csum_fail);
        chk("bad_fixes", exp_r.bad, act.bad);
        chk("good_fixes", exp_r.good, act.good);
        chk("dropped_lines", exp_r.dropped, act.dropped);
        chk("padding", exp_r.pad, act.pad);
      end
    end
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    gll_result_t exp_r;
    int unsigned rand_sent;
    int          pick;
    int          len;
    bit          long_done;
    bit          paused;
    rand_sent = 0;
    long_done = 1'b0;
    paused    = 1'b0;
    clear_line_state();
    in_drop = 1'b0;
    foreach (evt_cnt[i]) evt_cnt[i] = 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].ch);
      if (dir_tab[i].typed) begin
        exp_r         = result_q.pop_back();
        exp_r.outcome = dir_tab[i].oc;
        exp_r.csum    = dir_tab[i].sum;
        exp_r.lines   = dir_tab[i].lines;
        result_q.push_back(exp_r);
      end
    end
    drain_results();

    while (rand_sent < RAND_ITEMS) begin
      line_q.delete();
      pick = $urandom_range(0, 99);
      if ((!long_done && rand_sent >= 150) || pick < 3) begin
        // Over-long line; its terminator ends the drop.
        len = $urandom_range(ngll_pkg::LINE_CAPACITY, ngll_pkg::LINE_CAPACITY + 20);
        if ($urandom_range(0, 1) == 1) push_text(GLL_HEAD);
        while (line_q.size() < len) line_q.push_back(8'($urandom_range(32, 126)));
        long_done = 1'b1;
      end else if (pick < 11) begin
        repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_gll(pick < 25);
      end
      pick = $urandom_range(0, 2);
      if (pick == 0) line_q.push_back(ngll_pkg::CH_CR);
      if (pick != 2) line_q.push_back(ngll_pkg::CH_LF);
      else line_q.push_back(ngll_pkg::CH_CR);
      idle_pct = (rand_sent >= 260 && rand_sent < 420) ? 0 : 10;
      foreach (line_q[i]) begin
        send_byte(line_q[i]);
        rand_sent++;
      end
      if (!paused && rand_sent >= 200) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
